[rtl/core/adjacency_matrix_dfs_order_defines.svh]
// assertion macros for the adjacency matrix depth-first search block
// used by rtl/core modules that carry concurrent checks
`ifndef ADJACENCY_MATRIX_DFS_ORDER_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_DEFINES_SVH

// condition must hold in the same cycle
`define AMDFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition must hold in the next cycle
`define AMDFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/amdfs_pkg.sv]
// shared types, constants and helpers for the depth-first search block
// no dependencies; used by amdfs_ctrl, amdfs_datapath and the top level
package amdfs_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = VtxW + 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_row;
    logic start;
    logic step;
    logic emit_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;
    logic emit_last;
  } sts_t;

  // register index of vertex_count
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // clamp the vertex count register to 1..MaxVertices
  function automatic logic [CntW-1:0] active_count(logic [4:0] vc);
    logic [CntW-1:0] n;
    if (vc == 5'd0) begin
      n = CntW'(1);
    end else if ({1'b0, vc} > 6'(MaxVertices)) begin
      n = CntW'(MaxVertices);
    end else begin
      n = CntW'(vc);
    end
    return n;
  endfunction

  // bits below n set
  function automatic logic [MaxVertices-1:0] low_mask(logic [CntW-1:0] n);
    logic [MaxVertices-1:0] m;
    for (int i = 0; i < MaxVertices; i++) begin
      m[i] = (CntW'(i) < n);
    end
    return m;
  endfunction

  // index of lowest set bit, zero when none
  function automatic logic [VtxW-1:0] first_set(logic [MaxVertices-1:0] v);
    logic [VtxW-1:0] idx;
    idx = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = VtxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/amdfs_ctrl.sv]
// controller state machine: row loading, search stepping, result emission
// depends on amdfs_pkg
module amdfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  amdfs_pkg::sts_t  sts_i,
  output amdfs_pkg::cmd_t  cmd_o
);

  amdfs_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amdfs_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      amdfs_pkg::ST_LOAD: begin
        in_ready_o     = 1'b1;
        cmd_o.load_row = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.start = 1'b1;
          state_d     = amdfs_pkg::ST_SEARCH;
        end
      end
      amdfs_pkg::ST_SEARCH: begin
        if (sts_i.search_done) begin
          state_d = amdfs_pkg::ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      amdfs_pkg::ST_EMIT: begin
        out_valid_o    = 1'b1;
        cmd_o.emit_adv = out_ready_i;
        if (out_ready_i && sts_i.emit_last) begin
          state_d = amdfs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = amdfs_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

[rtl/core/amdfs_datapath.sv]
// datapath: adjacency rows, visited set, vertex stack and visit-order buffer
// depends on amdfs_pkg and adjacency_matrix_dfs_order_defines.svh
`include "adjacency_matrix_dfs_order_defines.svh"

module amdfs_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  amdfs_pkg::cmd_t                 cmd_i,
  output amdfs_pkg::sts_t                 sts_o,
  input  logic [amdfs_pkg::MaxVertices-1:0] row_i,
  input  logic [4:0]                      vertex_count_i,
  output logic [amdfs_pkg::VtxW-1:0]      vertex_o,
  output logic                            last_o,
  output logic                            was_path_o,
  output logic                            all_reached_o
);

  localparam int unsigned Nv = amdfs_pkg::MaxVertices;
  localparam int unsigned Vw = amdfs_pkg::VtxW;
  localparam int unsigned Cw = amdfs_pkg::CntW;

  // storage arrays (payload, no reset)
  logic [Nv-1:0] adj_q   [Nv];
  logic [Vw-1:0] stack_q [Nv];
  logic [Vw-1:0] order_q [Nv];

  // control state
  logic [Cw-1:0] row_cnt_q, row_cnt_d;
  logic [Nv-1:0] visited_q, visited_d;
  logic [Cw-1:0] depth_q, depth_d;
  logic [Cw-1:0] vis_cnt_q, vis_cnt_d;
  logic [Vw-1:0] out_idx_q, out_idx_d;
  logic [Cw-1:0] n_q, n_d;
  logic          path_q, path_d;

  logic [Cw-1:0] depth_m1;
  logic [Vw-1:0] top_vtx;
  logic [Nv-1:0] top_row;
  logic [Nv-1:0] free_mask;
  logic          found;
  logic [Vw-1:0] next_vtx;
  logic          finish;

  // neighbour search for the stack top
  always_comb begin
    depth_m1  = depth_q - Cw'(1);
    top_vtx   = stack_q[depth_m1[Vw-1:0]];
    top_row   = ({1'b0, top_vtx} < row_cnt_q) ? adj_q[top_vtx] : '0;
    free_mask = top_row & ~visited_q & amdfs_pkg::low_mask(n_q);
    found     = |free_mask;
    next_vtx  = amdfs_pkg::first_set(free_mask);
  end

  // status and result fields
  always_comb begin
    sts_o.search_done = (vis_cnt_q >= n_q) || (depth_q == '0);
    sts_o.emit_last   = ({1'b0, out_idx_q} + Cw'(1)) == vis_cnt_q;
    vertex_o          = order_q[out_idx_q];
    last_o            = sts_o.emit_last;
    was_path_o        = path_q;
    all_reached_o     = vis_cnt_q >= n_q;
    finish            = cmd_i.emit_adv && sts_o.emit_last;
  end

  // next values of control state
  always_comb begin
    row_cnt_d = row_cnt_q;
    visited_d = visited_q;
    depth_d   = depth_q;
    vis_cnt_d = vis_cnt_q;
    out_idx_d = out_idx_q;
    n_d       = n_q;
    path_d    = path_q;
    if (cmd_i.load_row && (row_cnt_q < Cw'(Nv))) begin
      row_cnt_d = row_cnt_q + Cw'(1);
    end
    if (cmd_i.start) begin
      visited_d = Nv'(1);
      depth_d   = Cw'(1);
      vis_cnt_d = Cw'(1);
      path_d    = 1'b1;
      n_d       = amdfs_pkg::active_count(vertex_count_i);
      out_idx_d = '0;
    end
    if (cmd_i.step) begin
      if (found) begin
        visited_d = visited_q | (Nv'(1) << next_vtx);
        depth_d   = depth_q + Cw'(1);
        vis_cnt_d = vis_cnt_q + Cw'(1);
      end else begin
        depth_d = depth_m1;
        path_d  = 1'b0;
      end
    end
    if (cmd_i.emit_adv) begin
      out_idx_d = out_idx_q + Vw'(1);
    end
    if (finish) begin
      row_cnt_d = '0;
      visited_d = '0;
      depth_d   = '0;
      vis_cnt_d = '0;
      out_idx_d = '0;
      path_d    = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      visited_q <= '0;
      depth_q   <= '0;
      vis_cnt_q <= '0;
      out_idx_q <= '0;
      n_q       <= Cw'(Nv);
      path_q    <= 1'b1;
    end else begin
      row_cnt_q <= row_cnt_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      vis_cnt_q <= vis_cnt_d;
      out_idx_q <= out_idx_d;
      n_q       <= n_d;
      path_q    <= path_d;
    end
  end

  // row store, stack and visit-order buffer writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && (row_cnt_q < Cw'(Nv))) begin
      adj_q[row_cnt_q[Vw-1:0]] <= row_i;
    end
    if (cmd_i.start) begin
      stack_q[0] <= '0;
      order_q[0] <= '0;
    end
    if (cmd_i.step && found) begin
      stack_q[depth_q[Vw-1:0]]   <= next_vtx;
      order_q[vis_cnt_q[Vw-1:0]] <= next_vtx;
    end
  end

  // checks
  `AMDFS_ASSERT_NOW(a_depth_le_visits, clk_i, rst_ni, 1'b1, depth_q <= vis_cnt_q,
    "stack deeper than visited count")
  `AMDFS_ASSERT_NOW(a_visit_count, clk_i, rst_ni, 1'b1,
    $countones(visited_q) == 32'(vis_cnt_q), "visited set and count disagree")
  `AMDFS_ASSERT_NOW(a_emit_in_range, clk_i, rst_ni, cmd_i.emit_adv,
    Cw'(out_idx_q) < vis_cnt_q, "result index past visit order")
  `AMDFS_ASSERT_NEXT(a_pop_clears_path, clk_i, rst_ni, cmd_i.step && !found,
    !path_q, "pop left path flag set")

endmodule

[rtl/core/adjacency_matrix_dfs_order.sv]
// Depth-first visit order of a graph of up to 16 vertices. Adjacency rows
// enter one per beat, row 0 first; the beat with tlast starts a search from
// vertex 0. The search is run by a single step unit (stack top read,
// priority encoder over the unvisited neighbours) that pushes or pops once
// per cycle until the search is done. The visit order is then sent one
// vertex per cycle while m_axis_tready is high, with was_path and
// all_reached equal on every beat of a search. Input is not accepted from
// the last row until the final result beat is taken.
// Registers: vertex_count at byte address 0 (reset 16; 0 acts as 1, above 16
// acts as 16). Write it only while the block is idle.
module adjacency_matrix_dfs_order (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] row_bits
  input  logic        s_axis_tlast,   // last_row
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] vertex, [4] was_path, [5] all_reached
  output logic        m_axis_tlast,   // last_result
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  amdfs_pkg::cmd_t           cmd;
  amdfs_pkg::sts_t           sts;
  logic [4:0]                vcount_q;
  logic [amdfs_pkg::VtxW-1:0] vertex;
  logic                      was_path;
  logic                      all_reached;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 5'd16;
    end else if (psel && penable && pwrite && (paddr[2] == amdfs_pkg::REG_VERTEX_COUNT)) begin
      vcount_q <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == amdfs_pkg::REG_VERTEX_COUNT) ? {27'd0, vcount_q} : 32'd0;

  amdfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  amdfs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .row_i          (s_axis_tdata),
    .vertex_count_i (vcount_q),
    .vertex_o       (vertex),
    .last_o         (m_axis_tlast),
    .was_path_o     (was_path),
    .all_reached_o  (all_reached)
  );

  // result beat packing
  assign m_axis_tdata = {2'b00, all_reached, was_path, vertex};

endmodule
